// ----- src/lktw_pkg.sv -----
`timescale 1ns / 1ps

package lktw_pkg;

    localparam int DISPLAY_BYTES = 4;

    localparam logic [1:0] OP_REFRESH = 2'd1;
    localparam logic [1:0] OP_KEY_READ = 2'd2;

    localparam logic [1:0] REG_DISPLAY_CONTROL = 2'd0;
    localparam logic [1:0] REG_PHASE_TICKS = 2'd1;
    localparam logic [1:0] REG_ACK_TIMEOUT = 2'd2;

    localparam logic [7:0] DISPLAY_CONTROL_RESET = 8'h8A;
    localparam logic [7:0] PHASE_TICKS_RESET = 8'd1;
    localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd50;

    localparam logic [7:0] CMD_DATA_SET = 8'h40;
    localparam logic [7:0] CMD_ADDRESS = 8'hC0;
    localparam logic [7:0] CMD_KEY_READ = 8'h46;

    localparam logic [5:0] STEP_IDLE = 6'd63;
    localparam logic [5:0] STEP_DATA_FIRST = 6'd7;
    localparam logic [5:0] STEP_DATA_END = 6'(7 + 2 * DISPLAY_BYTES);
    localparam logic [5:0] STEP_CONTROL_BYTE = 6'(7 + 2 * DISPLAY_BYTES + 2);

    typedef enum logic [2:0] {
        SEG_START,
        SEG_BYTE,
        SEG_ACK,
        SEG_READ,
        SEG_STOP,
        SEG_END
    } seg_kind_t;

    // Segment kind for a frame step of a refresh or a key read.
    function automatic seg_kind_t lktw_seg_kind(input logic key_op, input logic [5:0] step);
        logic [5:0] rel;
        seg_kind_t kind;
        rel = step - STEP_DATA_END;
        kind = SEG_END;
        if (key_op) begin
            case (step)
                6'd0: kind = SEG_START;
                6'd1: kind = SEG_BYTE;
                6'd2: kind = SEG_ACK;
                6'd3: kind = SEG_READ;
                6'd4: kind = SEG_ACK;
                6'd5: kind = SEG_STOP;
                default: kind = SEG_END;
            endcase
        end else if (step == 6'd0 || step == 6'd4) begin
            kind = SEG_START;
        end else if (step == 6'd1 || step == 6'd5) begin
            kind = SEG_BYTE;
        end else if (step == 6'd2 || step == 6'd6) begin
            kind = SEG_ACK;
        end else if (step == 6'd3) begin
            kind = SEG_STOP;
        end else if (step < STEP_DATA_END) begin
            kind = step[0] ? SEG_BYTE : SEG_ACK;
        end else begin
            case (rel)
                6'd0: kind = SEG_STOP;
                6'd1: kind = SEG_START;
                6'd2: kind = SEG_BYTE;
                6'd3: kind = SEG_ACK;
                6'd4: kind = SEG_STOP;
                default: kind = SEG_END;
            endcase
        end
        return kind;
    endfunction

endpackage

// ----- src/lktw_if.sv -----
`timescale 1ns / 1ps

interface lktw_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] disp_byte0;
    logic [7:0] disp_byte1;
    logic [7:0] disp_byte2;
    logic [7:0] disp_byte3;
    logic       dio_in;

    modport source (
        output valid, operation, disp_byte0, disp_byte1, disp_byte2, disp_byte3, dio_in,
        input  ready
    );
    modport sink (
        input  valid, operation, disp_byte0, disp_byte1, disp_byte2, disp_byte3, dio_in,
        output ready
    );
endinterface

interface lktw_out_if;
    logic       valid;
    logic       ready;
    logic       clk_level;
    logic       dio_level;
    logic       dio_drive;
    logic       busy_res;
    logic       key_valid;
    logic [3:0] key_code;
    logic       ack_missed;

    modport source (
        output valid, clk_level, dio_level, dio_drive, busy_res, key_valid, key_code,
               ack_missed,
        input  ready
    );
    modport sink (
        input  valid, clk_level, dio_level, dio_drive, busy_res, key_valid, key_code,
               ack_missed,
        output ready
    );
endinterface

// ----- src/led_key_two_wire_master_top.sv -----
`timescale 1ns / 1ps
// Two-wire master for an LED/key driver chip, advanced by one timer tick per word.
// in_ch carries one tick word: operation (refresh or key read start, else tick
// only), the four display bytes taken on a refresh start, and the sampled data pin.
// out_ch returns exactly one word per tick: clock and data pin levels, data pin
// drive enable, busy, a one-tick key_valid with key_code, and sticky ack_missed.
// Configuration writes (cfg_we, cfg_index, cfg_data) set the display-control byte,
// ticks per pin phase and the ack timeout; write them only while the block is idle.
// The result of a tick word is registered and is on out_ch in the cycle after it is accepted.
// Throughput: one tick word per cycle while out_ch does not stall; the pin sequencer
// state is updated by a single register stage, and the output register lets a new
// word in while the previous result is being taken.
// Reset: sequencer idle, pins clock high / data high / driven, registers at their
// defaults, no result pending.
// A stall on out_ch holds the result and drops in_ch.ready until it is taken.
module led_key_two_wire_master_top
    import lktw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    lktw_in_if.sink     in_ch,
    lktw_out_if.source  out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic [7:0] disp_ctrl_reg;
    logic [7:0] phase_ticks_reg;
    logic [7:0] ack_timeout_reg;

    logic [5:0] step_reg, step_next;
    logic [3:0] bit_reg, bit_next;
    logic [7:0] tx_reg, tx_next;
    logic [7:0] rx_reg, rx_next;
    logic [7:0] phase_reg, phase_next;
    logic [7:0] ack_reg, ack_next;
    logic [1:0] op_reg;
    logic [2:0] pins_reg, pins_next;
    logic       missed_reg, missed_next;
    logic [7:0] disp_reg [4];

    logic       out_valid_reg;
    logic [2:0] out_pins_reg;
    logic       out_busy_reg;
    logic       out_kvalid_reg;
    logic [3:0] out_kcode_reg;
    logic       out_missed_reg;

    logic       in_fire;
    logic       start;
    logic [1:0] cur_op;
    logic       key_op;
    logic [5:0] cur_step;
    logic [3:0] cur_bit;
    logic [7:0] cur_phase;
    logic [7:0] cur_ack;
    logic       busy;
    seg_kind_t  kind;
    seg_kind_t  next_kind;
    logic [5:0] step_inc;
    logic [5:0] data_rel;
    logic [4:0] data_idx;
    logic [7:0] next_byte;
    logic [3:0] last_bit;
    logic [7:0] ticks;
    logic [7:0] phase_inc;
    logic [7:0] ack_inc;
    logic       done;
    logic       clk_lvl, dat_lvl, drv_lvl;
    logic       kvalid;
    logic [3:0] kcode;

    assign in_fire = in_ch.valid && in_ch.ready;
    assign in_ch.ready = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        start     = (step_reg == STEP_IDLE) &&
                    (in_ch.operation == OP_REFRESH || in_ch.operation == OP_KEY_READ);
        cur_op    = start ? in_ch.operation : op_reg;
        key_op    = (cur_op == OP_KEY_READ);
        cur_step  = start ? 6'd0 : step_reg;
        cur_bit   = start ? 4'd0 : bit_reg;
        cur_phase = start ? 8'd0 : phase_reg;
        cur_ack   = start ? 8'd0 : ack_reg;
        busy      = (cur_step != STEP_IDLE);
        kind      = lktw_seg_kind(key_op, cur_step);
        step_inc  = cur_step + 6'd1;
        next_kind = lktw_seg_kind(key_op, step_inc);

        // byte loaded when the next segment is a byte
        data_rel = step_inc - STEP_DATA_FIRST;
        data_idx = data_rel[5:1];
        if (key_op) begin
            next_byte = CMD_KEY_READ;
        end else if (step_inc == 6'd1) begin
            next_byte = CMD_DATA_SET;
        end else if (step_inc == 6'd5) begin
            next_byte = CMD_ADDRESS;
        end else if (step_inc == STEP_CONTROL_BYTE) begin
            next_byte = disp_ctrl_reg;
        end else if (data_idx < 5'(DISPLAY_BYTES) && data_idx < 5'd4) begin
            next_byte = disp_reg[data_idx[1:0]];
        end else begin
            next_byte = 8'd0;
        end

        case (kind)
            SEG_BYTE, SEG_READ: last_bit = 4'd15;
            SEG_ACK:            last_bit = 4'd3;
            default:            last_bit = 4'd1;
        endcase

        ticks     = (phase_ticks_reg == 8'd0) ? 8'd1 : phase_ticks_reg;
        phase_inc = (cur_phase == 8'hFF) ? 8'hFF : cur_phase + 8'd1;
        ack_inc   = (cur_ack == 8'hFF) ? 8'hFF : cur_ack + 8'd1;

        clk_lvl = 1'b1;
        dat_lvl = 1'b1;
        drv_lvl = 1'b1;
        case (kind)
            SEG_START: dat_lvl = (cur_bit == 4'd0);
            SEG_BYTE:
            begin
                clk_lvl = cur_bit[0];
                dat_lvl = tx_reg[0];
            end
            SEG_ACK:
            begin
                if (cur_bit < 4'd2)
                begin
                    clk_lvl = 1'b0;
                    drv_lvl = 1'b0;
                end
                else
                begin
                    clk_lvl = (cur_bit == 4'd2);
                    dat_lvl = 1'b0;
                end
            end
            SEG_READ:
            begin
                clk_lvl = cur_bit[0];
                drv_lvl = 1'b0;
            end
            SEG_STOP: dat_lvl = (cur_bit != 4'd0);
            default: ;
        endcase

        step_next   = cur_step;
        bit_next    = cur_bit;
        tx_next     = tx_reg;
        rx_next     = start ? 8'd0 : rx_reg;
        phase_next  = cur_phase;
        ack_next    = cur_ack;
        missed_next = start ? 1'b0 : missed_reg;
        pins_next   = pins_reg;
        done        = 1'b0;
        kvalid      = 1'b0;
        kcode       = 4'd0;

        if (busy)
        begin
            // sample right after the clock rises
            if (kind == SEG_READ && cur_bit[0] && cur_phase == 8'd0)
                rx_next = {in_ch.dio_in, rx_next[7:1]};

            if (kind == SEG_ACK && cur_bit == 4'd1)
            begin
                if (!in_ch.dio_in)
                begin
                    done = 1'b1;
                end
                else
                begin
                    ack_next = ack_inc;
                    if (ack_inc >= ack_timeout_reg)
                    begin
                        missed_next = 1'b1;
                        done = 1'b1;
                    end
                end
            end
            else
            begin
                phase_next = phase_inc;
                done = (phase_inc >= ticks);
            end

            if (done)
            begin
                if (kind == SEG_BYTE && cur_bit[0])
                    tx_next = {1'b0, tx_reg[7:1]};
                phase_next = 8'd0;
                bit_next = cur_bit + 4'd1;
                if (cur_bit == last_bit)
                begin
                    bit_next = 4'd0;
                    ack_next = 8'd0;
                    if (next_kind == SEG_END)
                    begin
                        kvalid = key_op;
                        if (key_op)
                            kcode = rx_next[3] ? 4'hF : rx_next[3:0];
                        step_next = STEP_IDLE;
                    end
                    else
                    begin
                        step_next = step_inc;
                        if (next_kind == SEG_BYTE)
                            tx_next = next_byte;
                    end
                end
            end
            pins_next = {clk_lvl, dat_lvl, drv_lvl};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disp_ctrl_reg   <= DISPLAY_CONTROL_RESET;
            phase_ticks_reg <= PHASE_TICKS_RESET;
            ack_timeout_reg <= ACK_TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DISPLAY_CONTROL: disp_ctrl_reg <= cfg_data;
                REG_PHASE_TICKS:     phase_ticks_reg <= cfg_data;
                REG_ACK_TIMEOUT:     ack_timeout_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= STEP_IDLE;
            bit_reg    <= 4'd0;
            tx_reg     <= 8'd0;
            rx_reg     <= 8'd0;
            phase_reg  <= 8'd0;
            ack_reg    <= 8'd0;
            op_reg     <= 2'd0;
            pins_reg   <= 3'b111;
            missed_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            step_reg   <= step_next;
            bit_reg    <= bit_next;
            tx_reg     <= tx_next;
            rx_reg     <= rx_next;
            phase_reg  <= phase_next;
            ack_reg    <= ack_next;
            op_reg     <= cur_op;
            pins_reg   <= pins_next;
            missed_reg <= missed_next;
        end
    end

    // display bytes are taken on a refresh start
    always_ff @(posedge clk)
    begin
        if (in_fire && start && in_ch.operation == OP_REFRESH)
        begin
            disp_reg[0] <= in_ch.disp_byte0;
            disp_reg[1] <= in_ch.disp_byte1;
            disp_reg[2] <= in_ch.disp_byte2;
            disp_reg[3] <= in_ch.disp_byte3;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_pins_reg   <= busy ? {clk_lvl, dat_lvl, drv_lvl} : pins_reg;
            out_busy_reg   <= busy;
            out_kvalid_reg <= kvalid;
            out_kcode_reg  <= kcode;
            out_missed_reg <= missed_next;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.clk_level  = out_pins_reg[2];
    assign out_ch.dio_level  = out_pins_reg[1];
    assign out_ch.dio_drive  = out_pins_reg[0];
    assign out_ch.busy_res   = out_busy_reg;
    assign out_ch.key_valid  = out_kvalid_reg;
    assign out_ch.key_code   = out_kcode_reg;
    assign out_ch.ack_missed = out_missed_reg;

endmodule

// ----- src/lktw_checker.sv -----
`timescale 1ns / 1ps

module lktw_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       clk_level,
    input logic       dio_level,
    input logic       dio_drive,
    input logic       busy_res,
    input logic       key_valid,
    input logic [3:0] key_code,
    input logic       ack_missed
);

    // stalled word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(key_code) && $stable(busy_res)
            && $stable(clk_level) && $stable(dio_level) && $stable(ack_missed))
        else $error("stalled result word changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && key_valid |-> busy_res)
        else $error("key result outside a transaction");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && key_valid |-> key_code < 4'd8 || key_code == 4'd15)
        else $error("key code not folded to 15");

    // every transaction ends in a stop, so the bus rests driven high
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !busy_res |-> clk_level && dio_level && dio_drive && !key_valid)
        else $error("idle pins not at rest level");

endmodule

bind led_key_two_wire_master_top lktw_checker u_lktw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .clk_level  (out_ch.clk_level),
    .dio_level  (out_ch.dio_level),
    .dio_drive  (out_ch.dio_drive),
    .busy_res   (out_ch.busy_res),
    .key_valid  (out_ch.key_valid),
    .key_code   (out_ch.key_code),
    .ack_missed (out_ch.ack_missed)
);

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import lktw_pkg::*;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] disp_byte0;
        logic [7:0] disp_byte1;
        logic [7:0] disp_byte2;
        logic [7:0] disp_byte3;
        logic       dio_in;
    } tick_word_t;

    typedef struct packed {
        logic       clk_level;
        logic       dio_level;
        logic       dio_drive;
        logic       busy_res;
        logic       key_valid;
        logic [3:0] key_code;
        logic       ack_missed;
    } pin_word_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    lktw_in_if in_ch ();
    lktw_out_if out_ch ();

    led_key_two_wire_master_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Pin sequencer as the testbench sees it.
    logic [5:0] seq_step = STEP_IDLE;
    logic [3:0] seq_sub = '0;
    logic [7:0] seq_tx = '0;
    logic [7:0] seq_rx = '0;
    logic [7:0] seq_phase = '0;
    logic [7:0] seq_acks = '0;
    logic [1:0] seq_op = '0;
    logic [7:0] seq_disp [4];
    logic [2:0] seq_pins = 3'b111;
    logic       seq_missed = 1'b0;
    logic [7:0] reg_display_control = DISPLAY_CONTROL_RESET;
    logic [7:0] reg_phase_ticks = PHASE_TICKS_RESET;
    logic [7:0] reg_ack_timeout = ACK_TIMEOUT_RESET;

    pin_word_t expected_words [$];

    // Behavior of the chip on the data line.
    int ack_pull_pct = 100;
    int dio_noise_pct = 0;
    logic [7:0] key_scan_byte = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches = 0;
    int cycles = 0;

    function automatic seg_kind_t segment_of(input logic [5:0] step, output logic [7:0] tx_byte);
        int n2;
        int k;
        int tail;
        n2 = 2 * DISPLAY_BYTES;
        tx_byte = 8'h00;
        if (seq_op == OP_KEY_READ)
        begin
            case (step)
                6'd0: return SEG_START;
                6'd1:
                begin
                    tx_byte = CMD_KEY_READ;
                    return SEG_BYTE;
                end
                6'd2, 6'd4: return SEG_ACK;
                6'd3: return SEG_READ;
                6'd5: return SEG_STOP;
                default: return SEG_END;
            endcase
        end
        if (step == 6'd0 || step == 6'd4)
            return SEG_START;
        if (step == 6'd1)
        begin
            tx_byte = CMD_DATA_SET;
            return SEG_BYTE;
        end
        if (step == 6'd2 || step == 6'd6)
            return SEG_ACK;
        if (step == 6'd3)
            return SEG_STOP;
        if (step == 6'd5)
        begin
            tx_byte = CMD_ADDRESS;
            return SEG_BYTE;
        end
        if (int'(step) < 7 + n2)
        begin
            k = int'(step) - 7;
            if (k % 2 != 0)
                return SEG_ACK;
            // bytes past the fourth go out as zero
            if (k / 2 < 4)
                tx_byte = seq_disp[k / 2];
            return SEG_BYTE;
        end
        tail = int'(step) - (7 + n2);
        case (tail)
            0: return SEG_STOP;
            1: return SEG_START;
            2:
            begin
                tx_byte = reg_display_control;
                return SEG_BYTE;
            end
            3: return SEG_ACK;
            4: return SEG_STOP;
            default: return SEG_END;
        endcase
    endfunction

    function automatic int segment_length(input seg_kind_t kind);
        if (kind == SEG_BYTE || kind == SEG_READ)
            return 16;
        if (kind == SEG_ACK)
            return 4;
        return 2;
    endfunction

    function automatic void enter_segment();
        logic [7:0] tx_byte;
        seg_kind_t kind;
        kind = segment_of(seq_step, tx_byte);
        seq_sub = '0;
        seq_phase = '0;
        seq_acks = '0;
        if (kind == SEG_BYTE)
            seq_tx = tx_byte;
    endfunction

    function automatic pin_word_t predict_tick(input tick_word_t t);
        pin_word_t w;
        seg_kind_t kind;
        logic [7:0] tx_byte;
        logic [3:0] sub;
        logic [3:0] nib;
        logic done;
        logic clk_l;
        logic dat_l;
        logic drv_l;
        int ticks;
        w = '0;
        clk_l = 1'b1;
        dat_l = 1'b1;
        drv_l = 1'b1;
        ticks = (reg_phase_ticks == 8'd0) ? 1 : int'(reg_phase_ticks);

        if (seq_step == STEP_IDLE && (t.operation == OP_REFRESH || t.operation == OP_KEY_READ))
        begin
            seq_op = t.operation;
            if (t.operation == OP_REFRESH)
            begin
                seq_disp[0] = t.disp_byte0;
                seq_disp[1] = t.disp_byte1;
                seq_disp[2] = t.disp_byte2;
                seq_disp[3] = t.disp_byte3;
            end
            seq_missed = 1'b0;
            seq_rx = '0;
            seq_step = '0;
            enter_segment();
        end

        if (seq_step != STEP_IDLE)
        begin
            kind = segment_of(seq_step, tx_byte);
            sub = seq_sub;
            done = 1'b0;
            w.busy_res = 1'b1;
            case (kind)
                SEG_START: dat_l = (sub == 4'd0);
                SEG_BYTE:
                begin
                    clk_l = sub[0];
                    dat_l = seq_tx[0];
                end
                SEG_ACK:
                begin
                    if (sub < 4'd2)
                    begin
                        clk_l = 1'b0;
                        drv_l = 1'b0;
                    end
                    else
                    begin
                        clk_l = (sub == 4'd2);
                        dat_l = 1'b0;
                    end
                end
                SEG_READ:
                begin
                    clk_l = sub[0];
                    drv_l = 1'b0;
                    // sample once, on the first tick after the clock rises
                    if (sub[0] && seq_phase == 8'd0)
                        seq_rx = {t.dio_in, seq_rx[7:1]};
                end
                SEG_STOP: dat_l = (sub != 4'd0);
                default: ;
            endcase

            if (kind == SEG_ACK && sub == 4'd1)
            begin
                if (!t.dio_in)
                    done = 1'b1;
                else
                begin
                    if (seq_acks < 8'd255)
                        seq_acks = seq_acks + 8'd1;
                    if (seq_acks >= reg_ack_timeout)
                    begin
                        seq_missed = 1'b1;
                        done = 1'b1;
                    end
                end
            end
            else
            begin
                if (seq_phase < 8'd255)
                    seq_phase = seq_phase + 8'd1;
                if (int'(seq_phase) >= ticks)
                    done = 1'b1;
            end

            if (done)
            begin
                if (kind == SEG_BYTE && sub[0])
                    seq_tx = seq_tx >> 1;
                seq_phase = '0;
                seq_sub = seq_sub + 4'd1;
                if (seq_sub == 4'd0 || int'(seq_sub) >= segment_length(kind))
                begin
                    seq_step = seq_step + 6'd1;
                    if (segment_of(seq_step, tx_byte) == SEG_END)
                    begin
                        if (seq_op == OP_KEY_READ)
                        begin
                            nib = seq_rx[3:0];
                            w.key_valid = 1'b1;
                            w.key_code = nib[3] ? 4'hF : nib;
                        end
                        seq_step = STEP_IDLE;
                        seq_sub = '0;
                        seq_phase = '0;
                        seq_acks = '0;
                    end
                    else
                        enter_segment();
                end
            end
            seq_pins = {clk_l, dat_l, drv_l};
        end
        else
            {clk_l, dat_l, drv_l} = seq_pins;

        w.clk_level = clk_l;
        w.dio_level = dat_l;
        w.dio_drive = drv_l;
        w.ack_missed = seq_missed;
        return w;
    endfunction

    // Level the chip puts on the data line for the coming tick.
    function automatic logic chip_dio();
        seg_kind_t kind;
        logic [7:0] unused_byte;
        if (seq_step == STEP_IDLE || $urandom_range(99) < dio_noise_pct)
            return 1'($urandom_range(1));
        kind = segment_of(seq_step, unused_byte);
        if (kind == SEG_ACK && seq_sub == 4'd1)
            return ($urandom_range(99) < ack_pull_pct) ? 1'b0 : 1'b1;
        if (kind == SEG_READ)
            return key_scan_byte[seq_sub[3:1]];
        return 1'($urandom_range(1));
    endfunction

    function automatic string word_text(input pin_word_t w);
        return $sformatf("clk %b dio %b drv %b busy %b key %b/%h missed %b",
                         w.clk_level, w.dio_level, w.dio_drive, w.busy_res,
                         w.key_valid, w.key_code, w.ack_missed);
    endfunction

    task automatic send_tick(input logic [1:0] op, input logic [31:0] disp);
        tick_word_t t;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        t.operation = op;
        {t.disp_byte3, t.disp_byte2, t.disp_byte1, t.disp_byte0} = disp;
        t.dio_in = chip_dio();
        in_ch.valid <= 1'b1;
        in_ch.operation <= t.operation;
        in_ch.disp_byte0 <= t.disp_byte0;
        in_ch.disp_byte1 <= t.disp_byte1;
        in_ch.disp_byte2 <= t.disp_byte2;
        in_ch.disp_byte3 <= t.disp_byte3;
        in_ch.dio_in <= t.dio_in;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        expected_words.push_back(predict_tick(t));
    endtask

    task automatic finish_transaction();
        while (seq_step != STEP_IDLE)
            send_tick(OP_TICK, $urandom);
    endtask

    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
    endtask

    task automatic reconfigure(input logic [7:0] dc, input logic [7:0] pt, input logic [7:0] at);
        finish_transaction();
        wait_for_results();
        cfg_we <= 1'b1;
        cfg_index <= REG_DISPLAY_CONTROL;
        cfg_data <= dc;
        @(posedge clk);
        cfg_index <= REG_PHASE_TICKS;
        cfg_data <= pt;
        @(posedge clk);
        cfg_index <= REG_ACK_TIMEOUT;
        cfg_data <= at;
        @(posedge clk);
        cfg_we <= 1'b0;
        reg_display_control = dc;
        reg_phase_ticks = pt;
        reg_ack_timeout = at;
    endtask

    task automatic run_refresh(input logic [31:0] disp);
        send_tick(OP_REFRESH, disp);
        finish_transaction();
    endtask

    task automatic run_key_read(input logic [7:0] scan);
        key_scan_byte = scan;
        send_tick(OP_KEY_READ, $urandom);
        finish_transaction();
    endtask

    // Idle pins after reset, spare operation, refresh with the default registers.
    task automatic test_reset_state();
        ack_pull_pct = 100;
        dio_noise_pct = 0;
        repeat (3) send_tick(OP_TICK, 32'hFFFF_FFFF);
        send_tick(OP_SPARE, 32'h0000_0000);
        run_refresh(32'h5AA5_FF00);
        run_refresh(32'hFFFF_FFFF);
        run_refresh(32'h0000_0000);
    endtask

    // Nibbles below eight come back as read, eight and above read as fifteen.
    task automatic test_key_codes();
        logic [7:0] scans [5];
        scans = '{8'h07, 8'h08, 8'hF0, 8'hFF, 8'h00};
        ack_pull_pct = 100;
        dio_noise_pct = 0;
        foreach (scans[i])
            run_key_read(scans[i]);
    endtask

    task automatic test_ack_timeouts();
        reconfigure(8'h00, 8'd1, 8'd1);
        ack_pull_pct = 0;
        run_refresh($urandom);
        // missed flag holds while idle and clears on the next start
        repeat (3) send_tick(OP_TICK, $urandom);
        ack_pull_pct = 100;
        run_key_read(8'h3C);
        reconfigure(8'hFF, 8'd2, 8'd255);
        ack_pull_pct = 0;
        run_key_read(8'h81);
        ack_pull_pct = 90;
        run_refresh($urandom);
        // zero phase length and zero timeout
        reconfigure(8'h8F, 8'd0, 8'd0);
        ack_pull_pct = 50;
        run_refresh($urandom);
        run_key_read(8'h0B);
    endtask

    task automatic test_start_while_busy();
        int n;
        reconfigure(8'($urandom), 8'd1, 8'd4);
        ack_pull_pct = 80;
        dio_noise_pct = 10;
        send_tick(OP_REFRESH, $urandom);
        n = 0;
        while (seq_step != STEP_IDLE)
        begin
            n++;
            if (n % 7 == 0)
                send_tick(2'($urandom_range(1, 3)), $urandom);
            else
                send_tick(OP_TICK, $urandom);
        end
        key_scan_byte = 8'($urandom);
        send_tick(OP_KEY_READ, $urandom);
        send_tick(OP_REFRESH, $urandom);
        send_tick(OP_KEY_READ, $urandom);
        finish_transaction();
        dio_noise_pct = 0;
    endtask

    task automatic random_phase(input int words);
        int r;
        logic [1:0] op;
        reconfigure(8'($urandom),
                    ($urandom_range(99) < 80) ? 8'($urandom_range(1, 3)) : 8'($urandom_range(4, 12)),
                    ($urandom_range(99) < 70) ? 8'($urandom_range(1, 6)) :
                    ($urandom_range(99) < 75) ? 8'($urandom_range(7, 40)) : 8'd255);
        for (int i = 0; i < words; i++)
        begin
            if (seq_step == STEP_IDLE)
            begin
                r = $urandom_range(99);
                op = (r < 35) ? OP_REFRESH : (r < 70) ? OP_KEY_READ : (r < 73) ? OP_SPARE : OP_TICK;
                if (op == OP_REFRESH || op == OP_KEY_READ)
                begin
                    r = $urandom_range(3);
                    ack_pull_pct = (r == 0) ? 100 : (r == 1) ? 80 : (r == 2) ? 30 : 0;
                    dio_noise_pct = ($urandom_range(99) < 20) ? 10 : 0;
                    key_scan_byte = 8'($urandom);
                end
            end
            else
                op = ($urandom_range(99) < 5) ? 2'($urandom_range(1, 3)) : OP_TICK;
            send_tick(op, $urandom);
        end
        finish_transaction();
    endtask

    task automatic test_random();
        send_idle_pct = 38;
        recv_idle_pct = 60;
        repeat (3) random_phase(190);
        send_idle_pct = 60;
        recv_idle_pct = 38;
        repeat (3) random_phase(190);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (3) random_phase(190);
    endtask

    // Long phases: one key read at a long phase length, then a refresh at the shortest phase length.
    task automatic test_slow_phases();
        reconfigure(8'h88, 8'd16, 8'd3);
        ack_pull_pct = 100;
        dio_noise_pct = 0;
        run_key_read(8'hA6);
        reconfigure(DISPLAY_CONTROL_RESET, 8'd1, 8'd255);
        ack_pull_pct = 70;
        run_refresh($urandom);
    endtask

    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_ch.ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_words
        pin_word_t want;
        pin_word_t got;
        if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            got.clk_level = out_ch.clk_level;
            got.dio_level = out_ch.dio_level;
            got.dio_drive = out_ch.dio_drive;
            got.busy_res = out_ch.busy_res;
            got.key_valid = out_ch.key_valid;
            got.key_code = out_ch.key_code;
            got.ack_missed = out_ch.ack_missed;
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected word at %0t: %s", $realtime, word_text(got));
            end
            else
            begin
                want = expected_words.pop_front();
                if (got.clk_level !== want.clk_level || got.dio_level !== want.dio_level ||
                    got.dio_drive !== want.dio_drive || got.busy_res !== want.busy_res ||
                    got.key_valid !== want.key_valid || got.key_code !== want.key_code ||
                    got.ack_missed !== want.ack_missed)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("mismatch at %0t: expected %s, got %s",
                                 $realtime, word_text(want), word_text(got));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_DISPLAY_CONTROL;
        cfg_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.operation <= OP_TICK;
        in_ch.disp_byte0 <= '0;
        in_ch.disp_byte1 <= '0;
        in_ch.disp_byte2 <= '0;
        in_ch.disp_byte3 <= '0;
        in_ch.dio_in <= 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 38;
        recv_idle_pct = 60;
        test_reset_state();
        test_key_codes();
        test_ack_timeouts();
        test_start_while_busy();
        test_random();
        test_slow_phases();

        finish_transaction();
        wait_for_results();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
